>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk; FDF_ASSERT takes rst as the disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, including during reset.
`define FDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared widths and control types of the flooding duplicate filter.
// ----------------------------------------------------------------------------
package fdf_pkg;

  // Origin address field as carried on the packet channel.
  localparam int ORIGIN_W = 16;
  // Width of the reported entry count.
  localparam int HELD_W = 7;

  // Per-cycle strobes from the sequencer to the address table.
  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_ctl_t;

endpackage

>>> hdl/fdf_table.sv
// ----------------------------------------------------------------------------
// fdf_table
// Origin address store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdf_table import fdf_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  tbl_ctl_t         ctl,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/fdf_match.sv
// ----------------------------------------------------------------------------
// fdf_match
// Shared compare unit: tracks the read in flight and checks the returned
// entry against the search key.
// ----------------------------------------------------------------------------
module fdf_match #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             issue,
  input  logic [WIDTH-1:0] key,
  input  logic [WIDTH-1:0] data,
  output logic             pend,
  output logic             hit
);

  // data is valid the cycle after a read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue;
    end
  end

  assign hit = pend && (data == key);

endmodule

>>> hdl/flood_duplicate_filter_core.sv
// ----------------------------------------------------------------------------
// flood_duplicate_filter_core
// Duplicate suppression for flooded packets: forwards a right-length packet whose origin
// is not yet held and appends that origin; a period tick empties the table.
// ----------------------------------------------------------------------------
// One transaction at a time. A period tick, a wrong-length packet or a packet
// arriving at an empty table gives its result the cycle after acceptance. A
// checked packet scans the held entries through the single table read port,
// one entry per cycle, and a match ends the scan early. A new packet is
// accepted once the previous result has been taken. The table needs no
// clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flood_duplicate_filter_core import fdf_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int ADDR_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  output logic                pkt_stall,
  input  logic                cmd,
  input  logic [ORIGIN_W-1:0] origin_addr,
  input  logic                length_ok,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                forward,
  output logic [HELD_W-1:0]   entries_held
);

  localparam int CNT_W = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                state;
  logic [ADDR_WIDTH-1:0] key;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;

  logic                  accept;
  logic                  rd_issue;
  logic                  pend;
  logic                  hit;
  logic                  miss_done;
  logic [CNT_W-1:0]      app_addr;
  logic [CNT_W-1:0]      app_count;
  logic [ADDR_WIDTH-1:0] origin_ext;
  logic [ADDR_WIDTH-1:0] rd_data;
  logic [ADDR_WIDTH-1:0] wr_data;
  tbl_ctl_t              ctl;

  function automatic logic [HELD_W-1:0] held7(input logic [CNT_W-1:0] c);
    logic [CNT_W+HELD_W-1:0] w;
    w = {HELD_W'(0), c};
    return w[HELD_W-1:0];
  endfunction

  assign pkt_stall  = (state != S_IDLE);
  assign accept     = pkt_valid && !pkt_stall;
  assign origin_ext = ADDR_WIDTH'(origin_addr);

  assign rd_issue  = (state == S_SCAN) && (idx != count);
  assign miss_done = (state == S_SCAN) && pend && !hit && (idx == count);

  // table holding TABLE_DEPTH-1 entries restarts at entry 0
  assign app_addr  = (count >= LAST) ? '0 : count;
  assign app_count = app_addr + CNT_W'(1);

  assign ctl = '{rd: rd_issue,
                 wr: (accept && !cmd && length_ok && (count == '0)) || miss_done};
  assign wr_data = (state == S_IDLE) ? origin_ext : key;

  fdf_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ADDR_WIDTH),
    .AW    (CNT_W)
  ) u_table (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_addr (app_addr),
    .wr_data (wr_data)
  );

  fdf_match #(
    .WIDTH (ADDR_WIDTH)
  ) u_match (
    .clk   (clk),
    .rst   (rst),
    .issue (rd_issue),
    .key   (key),
    .data  (rd_data),
    .pend  (pend),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            key <= origin_ext;
            idx <= '0;
            if (cmd) begin
              count        <= '0;
              forward      <= 1'b0;
              entries_held <= '0;
              res_valid    <= 1'b1;
              state        <= S_DONE;
            end else if (!length_ok) begin
              forward      <= 1'b0;
              entries_held <= held7(count);
              res_valid    <= 1'b1;
              state        <= S_DONE;
            end else if (count == '0) begin
              count        <= app_count;
              forward      <= 1'b1;
              entries_held <= held7(app_count);
              res_valid    <= 1'b1;
              state        <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_issue) begin
            idx <= idx + CNT_W'(1);
          end
          if (hit) begin
            forward      <= 1'b0;
            entries_held <= held7(count);
            res_valid    <= 1'b1;
            state        <= S_DONE;
          end else if (miss_done) begin
            count        <= app_count;
            forward      <= 1'b1;
            entries_held <= held7(app_count);
            res_valid    <= 1'b1;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state     <= S_IDLE;
          res_valid <= 1'b0;
        end
      endcase
    end
  end

  `FDF_ASSERT(a_count_range, count <= LAST, "entry count beyond table depth")
  `FDF_ASSERT(a_tick_clears, accept && cmd |=> count == '0, "period tick left entries")
  `FDF_ASSERT(a_scan_idx, (state == S_SCAN) |-> idx <= count, "scan ran past held entries")
  `FDF_ASSERT(a_fwd_appended, $rose(res_valid) && forward |-> count != '0,
              "forwarded transaction without an appended entry")
  `FDF_ASSERT(a_port_clash, !(ctl.rd && ctl.wr), "table read and write together")

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flood_duplicate_filter_core: packets and period
// ticks go in through a bursty driver, every verdict is checked against a
// local copy of the seen-address table, and the result side stalls randomly.
// ----------------------------------------------------------------------------
module tb import fdf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 128;
  localparam int ADDR_WIDTH   = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int LIMIT_CYCLES = 600000;
  localparam int TAIL_CYCLES  = 160;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_PERIOD = 1'b1;

  typedef struct {
    logic                cmd;
    logic [ORIGIN_W-1:0] addr;
    logic                len_ok;
    bit                  hold;   // wait for all verdicts before presenting
  } packet_t;

  typedef struct {
    logic              fwd;
    logic [HELD_W-1:0] held;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                pkt_valid = 1'b0;
  logic                pkt_stall;
  logic                cmd = CMD_PACKET;
  logic [ORIGIN_W-1:0] origin_addr = '0;
  logic                length_ok = 1'b0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic                forward;
  logic [HELD_W-1:0]   entries_held;

  packet_t  packets_to_send[$];
  verdict_t verdicts_due[$];

  // shadow of the address table
  logic [ORIGIN_W-1:0] seen_tbl[TABLE_DEPTH];
  int unsigned         seen_n = 0;

  int errors = 0;
  int cycles = 0;
  int n_fwd = 0, n_drop = 0, n_ignored = 0, n_ticks = 0, n_restarts = 0;
  int n_checked = 0;

  flood_duplicate_filter_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .cmd         (cmd),
    .origin_addr (origin_addr),
    .length_ok   (length_ok),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .forward     (forward),
    .entries_held(entries_held)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  function automatic void judge_packet(logic c, logic [ORIGIN_W-1:0] a, logic ok);
    verdict_t v;
    bit       held_already;
    v.fwd = 1'b0;
    held_already = 1'b0;
    if (c == CMD_PERIOD) begin
      seen_n = 0;
      n_ticks++;
    end else if (!ok) begin
      n_ignored++;
    end else begin
      for (int i = 0; i < seen_n && i < TABLE_DEPTH; i++)
        if (seen_tbl[i] == a) held_already = 1'b1;
      if (held_already) begin
        n_drop++;
      end else begin
        if (seen_n >= TABLE_DEPTH - 1) begin
          seen_n = 0;
          n_restarts++;
        end
        seen_tbl[seen_n] = a;
        seen_n++;
        v.fwd = 1'b1;
        n_fwd++;
      end
    end
    v.held = HELD_W'(seen_n);
    verdicts_due.push_back(v);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    bit      busy;
    packet_t p;
    if (rst) begin
      pkt_valid <= 1'b0;
    end else begin
      busy = pkt_valid;
      if (pkt_valid && !pkt_stall) begin
        judge_packet(cmd, origin_addr, length_ok);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          pkt_valid <= 1'b0;
        end else if (packets_to_send.size() > 0 &&
                     !(packets_to_send[0].hold && verdicts_due.size() != 0)) begin
          p = packets_to_send.pop_front();
          cmd         <= p.cmd;
          origin_addr <= p.addr;
          length_ok   <= p.len_ok;
          pkt_valid   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          pkt_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: phases of no stall, scattered stalls and long runs.
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;

  always @(posedge clk) begin : stall_gen
    logic nxt;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: nxt = 1'b0;
        1: nxt = ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left > 0) begin
            run_left--;
            nxt = res_stall;
          end else begin
            nxt = ~res_stall;
            run_left = $urandom_range(0, 20);
          end
        end
      endcase
      res_stall <= nxt;
    end
  end

  always @(posedge clk) begin : watch
    verdict_t v;
    if (!rst && res_valid && !res_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected transaction: forward=%0d entries_held=%0d", forward, entries_held);
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        n_checked++;
        if (forward !== v.fwd) begin
          $error("forward: expected %0d, got %0d", v.fwd, forward);
          errors++;
        end
        if (entries_held !== v.held) begin
          $error("entries_held: expected %0d, got %0d", v.held, entries_held);
          errors++;
        end
      end
    end
  end

  int counted = 0;

  task automatic add_item(logic c, logic [ORIGIN_W-1:0] a, logic ok, bit hold = 0);
    packet_t p;
    p.cmd = c;
    p.addr = a;
    p.len_ok = ok;
    p.hold = hold;
    packets_to_send.push_back(p);
    counted++;
  endtask

  // Run of distinct origins with the odd repeat of a recent one mixed in.
  task automatic add_fresh_run(int n);
    logic [ORIGIN_W-1:0] base;
    base = ORIGIN_W'($urandom);
    for (int i = 0; i < n; i++) begin
      add_item(CMD_PACKET, base + ORIGIN_W'(i), 1'b1);
      if (i > 0 && $urandom_range(0, 7) == 0)
        add_item(CMD_PACKET, base + ORIGIN_W'($urandom_range(0, i)), 1'b1);
    end
  endtask

  initial begin : stimulus
    int                  kind;
    int                  run;
    int                  pool_sz;
    logic [ORIGIN_W-1:0] pool_base;
    bit                  timed_out;

    // directed
    add_item(CMD_PACKET, 16'h0000, 1'b1);      // empty table
    add_item(CMD_PACKET, 16'h0000, 1'b1);      // duplicate
    add_item(CMD_PACKET, 16'hFFFF, 1'b1);
    add_item(CMD_PACKET, 16'hFFFF, 1'b1);
    add_item(CMD_PACKET, 16'h1234, 1'b0);      // wrong length, ignored
    add_item(CMD_PACKET, 16'h1234, 1'b1);      // still new
    add_item(CMD_PACKET, 16'h8000, 1'b1);
    add_item(CMD_PACKET, 16'h7FFF, 1'b1);
    add_item(CMD_PACKET, 16'h0000, 1'b1);      // match on first entry
    add_item(CMD_PACKET, 16'h7FFF, 1'b1);      // match on last entry
    add_item(CMD_PERIOD, 16'hFFFF, 1'b1, 1);
    add_item(CMD_PACKET, 16'h0000, 1'b1);      // new again after tick
    add_item(CMD_PERIOD, 16'h0000, 1'b0);
    add_item(CMD_PERIOD, 16'hFFFF, 1'b0);      // tick on empty table
    add_item(CMD_PACKET, 16'hFFFF, 1'b0);      // wrong length on empty table
    add_item(CMD_PACKET, 16'hAAAA, 1'b1);
    add_item(CMD_PACKET, 16'h5555, 1'b1);
    add_item(CMD_PACKET, 16'hAAAA, 1'b1);
    add_item(CMD_PACKET, 16'h5555, 1'b1, 1);

    // random: start with a run long enough to restart the table
    counted = 0;
    add_fresh_run($urandom_range(130, 140));
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        pool_base = ORIGIN_W'($urandom);
        pool_sz = $urandom_range(1, 12);
        run = $urandom_range(5, 30);
        for (int i = 0; i < run; i++)
          add_item(CMD_PACKET, pool_base + ORIGIN_W'($urandom_range(0, pool_sz - 1)),
                   $urandom_range(0, 9) != 0);
      end else if (kind < 60) begin
        add_fresh_run($urandom_range(10, 140));
      end else if (kind < 70) begin
        add_item(CMD_PERIOD, ORIGIN_W'($urandom), 1'($urandom_range(0, 1)));
      end else if (kind < 90) begin
        run = $urandom_range(1, 10);
        for (int i = 0; i < run; i++)
          add_item(($urandom_range(0, 9) == 0) ? CMD_PERIOD : CMD_PACKET,
                   ORIGIN_W'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        add_item(CMD_PACKET, ORIGIN_W'($urandom), 1'b1, 1);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while ((packets_to_send.size() != 0 || pkt_valid || verdicts_due.size() != 0) &&
           cycles < LIMIT_CYCLES)
      @(posedge clk);
    timed_out = (cycles >= LIMIT_CYCLES);
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $error("%0d verdicts never arrived", verdicts_due.size());
      errors++;
    end

    $display("checked %0d transactions: %0d forwarded, %0d dropped, %0d ignored",
             n_checked, n_fwd, n_drop, n_ignored);
    $display("%0d period ticks, %0d table restarts, %0d cycles", n_ticks, n_restarts, cycles);
    if (timed_out) begin
      $display("timeout after %0d cycles", cycles);
      $display("[flood_duplicate_filter_core] ERROR");
    end else if (errors == 0) begin
      $display("[flood_duplicate_filter_core] OK");
    end else begin
      $display("[flood_duplicate_filter_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/fdf_pkg.sv
hdl/fdf_table.sv
hdl/fdf_match.sv
hdl/flood_duplicate_filter_core.sv
test/tb.sv
